// ===== hdl/rmst_pkg.sv =====
// Shared types, constants and helpers for the range-minimum segment tree.
// No dependencies; the top level and rmst_core import this package.
`default_nettype none

package rmst_pkg;

  // Tree geometry
  localparam int unsigned LEAVES     = 1024;
  localparam int unsigned LEAF_BITS  = $clog2(LEAVES);
  localparam int unsigned BASE       = 1 << LEAF_BITS;
  localparam int unsigned NODE_DEPTH = 2 * BASE;
  localparam int unsigned NODE_AW    = LEAF_BITS + 1;
  // Open query bounds can reach 2*BASE, one bit past the node address.
  localparam int unsigned BOUND_W    = LEAF_BITS + 2;

  // Field widths
  localparam int unsigned POS_W       = 11;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IN_TDATA_W  = ((2 * POS_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;

  localparam logic signed [VAL_W-1:0] NEUTRAL    = VAL_W'(1000000005);
  localparam logic [POS_W-1:0]        LEAVES_POS = POS_W'(LEAVES);

  typedef enum logic {
    MODE_SET   = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_OUT
  } state_e;

  typedef logic [NODE_AW-1:0]        node_addr_t;
  typedef logic [BOUND_W-1:0]        bound_t;
  typedef logic signed [VAL_W-1:0]   value_t;

  // Request to the two mirrored node memories: one shared write, two reads.
  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    value_t     wdata;
    node_addr_t raddr_a;
    node_addr_t raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic   valid;
    value_t data;
  } res_t;

  function automatic value_t smin(value_t a, value_t b);
    return (a < b) ? a : b;
  endfunction

  // Node index lies inside the tree (not zero, below 2*BASE).
  function automatic logic in_tree(bound_t i);
    return !i[BOUND_W-1] && (i != '0);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/range_minimum_segment_tree_top.sv =====
// Range-minimum segment tree: top level with stream ports, node memories and result register.
// Depends on rmst_pkg, rmst_ram and rmst_core.
// Operation: an update writes the leaf and then one parent per level up to the root; a query
//   walks its two bounds up one tree level per step, and an empty range goes straight to the
//   result; a result-side stall holds a finished query until the result register takes it.
// Items are taken one at a time: s_axis_tready stays low until the current item is done.
// Reset: asynchronous, active low; then a clearing pass writes the neutral
//   value into every node, with s_axis_tready low until it ends.
`default_nettype none

module range_minimum_segment_tree_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [10:0] position, [21:11] right_end, [53:22] new_value, [55:54] zero
  input  wire logic [rmst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] mode (0 set leaf, 1 range query)
  input  wire logic [0:0]                        s_axis_tuser,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] range_min
  output logic      [rmst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import rmst_pkg::*;

  mode_e            in_mode;
  logic [POS_W-1:0] in_position, in_right_end;
  value_t           in_new_value;
  value_t           rd_a, rd_b;
  mem_req_t         mem_req;
  res_t             res;
  logic             res_ready;

  logic             m_valid_q, m_valid_d;
  value_t           m_data_q;

  // Unpack the input transfer.
  assign in_mode      = mode_e'(s_axis_tuser[0]);
  assign in_position  = s_axis_tdata[POS_W-1:0];
  assign in_right_end = s_axis_tdata[2*POS_W-1:POS_W];
  assign in_new_value = s_axis_tdata[2*POS_W+VAL_W-1:2*POS_W];

  rmst_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_mode_i      (in_mode),
    .in_position_i  (in_position),
    .in_right_end_i (in_right_end),
    .in_new_value_i (in_new_value),
    .rd_a_i         (rd_a),
    .rd_b_i         (rd_b),
    .mem_req_o      (mem_req),
    .res_o          (res),
    .res_ready_i    (res_ready)
  );

  // Two mirrored copies of the node array: every write goes to both, so the
  // query walk reads its left and right neighbors in the same cycle.
  rmst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODE_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr_a),
    .rdata_o (rd_a)
  );

  rmst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODE_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr_b),
    .rdata_o (rd_b)
  );

  // Result register: load when empty or draining this cycle, drop on transfer.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res.valid && res_ready) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      m_data_q <= res.data;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

endmodule

`default_nettype wire

// ===== hdl/rmst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rmst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/rmst_core.sv =====
// Sequencer and datapath of the segment tree: clear sweep, leaf-to-root
// update and two-bound query walk over the mirrored node memories. Uses rmst_pkg.
`default_nettype none

module rmst_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire rmst_pkg::mode_e                in_mode_i,
  input  wire logic [rmst_pkg::POS_W-1:0]     in_position_i,
  input  wire logic [rmst_pkg::POS_W-1:0]     in_right_end_i,
  input  wire rmst_pkg::value_t               in_new_value_i,
  input  wire rmst_pkg::value_t               rd_a_i,
  input  wire rmst_pkg::value_t               rd_b_i,
  output rmst_pkg::mem_req_t                  mem_req_o,
  output rmst_pkg::res_t                      res_o,
  input  wire logic                           res_ready_i
);
  import rmst_pkg::*;

  state_e     state_q, state_d;
  node_addr_t clr_cnt_q, clr_cnt_d;
  logic       take_a_q, take_a_d;
  logic       take_b_q, take_b_d;
  node_addr_t idx_q, idx_d;
  value_t     cur_q, cur_d;
  bound_t     lo_q, lo_d;
  bound_t     hi_q, hi_d;
  value_t     best_q, best_d;

  logic             in_fire;
  logic             pos_ok;
  logic [POS_W-1:0] q_left, q_right;
  logic             q_empty;
  node_addr_t       leaf_idx, parent;
  bound_t           lo_init, hi_init, lo_nb, hi_nb;
  logic             walk_go;
  value_t           fold_a, fold_b, fold_min, upd_min;

  assign in_fire  = in_valid_i && in_ready_o;
  assign pos_ok   = (in_position_i != '0) && (in_position_i <= LEAVES_POS);
  assign q_left   = (in_position_i == '0) ? POS_W'(1) : in_position_i;
  assign q_right  = (in_right_end_i > LEAVES_POS) ? LEAVES_POS : in_right_end_i;
  assign q_empty  = q_left > q_right;
  assign leaf_idx = NODE_AW'(in_position_i) + NODE_AW'(BASE - 1);
  assign lo_init  = BOUND_W'(q_left) + BOUND_W'(BASE) - BOUND_W'(2);
  assign hi_init  = BOUND_W'(q_right) + BOUND_W'(BASE);

  assign parent   = {1'b0, idx_q[NODE_AW-1:1]};
  assign upd_min  = smin(cur_q, rd_a_i);

  assign lo_nb    = lo_q + BOUND_W'(1);
  assign hi_nb    = hi_q - BOUND_W'(1);
  assign walk_go  = lo_q[BOUND_W-1:1] != hi_q[BOUND_W-1:1];

  // Fold the reads issued in the previous walk step.
  assign fold_a   = take_a_q ? rd_a_i : NEUTRAL;
  assign fold_b   = take_b_q ? rd_b_i : NEUTRAL;
  assign fold_min = smin(best_q, smin(fold_a, fold_b));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR: begin
        if (&clr_cnt_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode_i == MODE_SET) begin
            state_d = pos_ok ? ST_UPD : ST_IDLE;
          end else begin
            state_d = q_empty ? ST_OUT : ST_QRY;
          end
        end
      end
      ST_UPD: begin
        if (idx_q[NODE_AW-1:1] == (NODE_AW-1)'(1)) state_d = ST_IDLE;
      end
      ST_QRY: begin
        if (!walk_go) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    res_o.valid = (state_q == ST_OUT);
    res_o.data  = best_q;
  end

  // Datapath and memory requests
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    take_a_d  = 1'b0;
    take_b_d  = 1'b0;
    idx_d     = idx_q;
    cur_d     = cur_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    best_d    = best_q;
    mem_req_o = '{we: 1'b0, waddr: '0, wdata: NEUTRAL, raddr_a: '0, raddr_b: '0};
    unique case (state_q)
      ST_CLR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_cnt_q;
        clr_cnt_d       = clr_cnt_q + NODE_AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode_i == MODE_SET) begin
            if (pos_ok) begin
              mem_req_o.we      = 1'b1;
              mem_req_o.waddr   = leaf_idx;
              mem_req_o.wdata   = in_new_value_i;
              mem_req_o.raddr_a = leaf_idx ^ NODE_AW'(1);
              idx_d             = leaf_idx;
              cur_d             = in_new_value_i;
            end
          end else begin
            best_d = NEUTRAL;
            lo_d   = lo_init;
            hi_d   = hi_init;
          end
        end
      end
      ST_UPD: begin
        // Sibling arrives now; write the parent, fetch the parent's sibling.
        mem_req_o.we      = 1'b1;
        mem_req_o.waddr   = parent;
        mem_req_o.wdata   = upd_min;
        mem_req_o.raddr_a = parent ^ NODE_AW'(1);
        cur_d             = upd_min;
        idx_d             = parent;
      end
      ST_QRY: begin
        best_d            = fold_min;
        mem_req_o.raddr_a = lo_nb[NODE_AW-1:0];
        mem_req_o.raddr_b = hi_nb[NODE_AW-1:0];
        take_a_d          = walk_go && !lo_q[0] && in_tree(lo_nb);
        take_b_d          = walk_go && hi_q[0] && in_tree(hi_nb);
        lo_d              = lo_q >> 1;
        hi_d              = hi_q >> 1;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      take_a_q  <= 1'b0;
      take_b_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      take_a_q  <= take_a_d;
      take_b_q  <= take_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    best_q <= best_d;
  end

`ifndef SYNTHESIS
  a_upd_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> mem_req_o.waddr != mem_req_o.raddr_a)
    else $error("update writes the node it reads");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QRY |-> lo_q < hi_q)
    else $error("query bounds crossed");

  a_upd_ends_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && state_d == ST_IDLE) |-> mem_req_o.waddr == NODE_AW'(1))
    else $error("update finished below the root");

  a_take_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_a_q || take_b_q) |-> $past(state_q) == ST_QRY)
    else $error("fold flag outside the query walk");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for range_minimum_segment_tree_top: leaf updates and range queries
// on the input stream, results checked against a segment-tree predictor in a scoreboard class.
// Depends on rmst_pkg and the block's RTL only.

module testbench;
  import rmst_pkg::*;

  // Predicts every range minimum from its own copy of the tree and checks results in order.
  class range_min_scoreboard;
    value_t tree [NODE_DEPTH];
    value_t pending_min [$];
    int     fail_count;

    function new();
      foreach (tree[i]) tree[i] = NEUTRAL;
      fail_count = 0;
    endfunction

    // Index zero and anything past the last node count as neutral.
    function value_t node_at(int unsigned idx);
      if (idx == 0 || idx >= NODE_DEPTH) return NEUTRAL;
      return tree[idx];
    endfunction

    function value_t lesser(value_t a, value_t b);
      return (a < b) ? a : b;
    endfunction

    function void note_transfer(mode_e mode, logic [POS_W-1:0] pos, logic [POS_W-1:0] rend,
                                value_t value);
      int unsigned idx;
      int unsigned left_b;
      int unsigned right_b;
      int unsigned lo;
      int unsigned hi;
      value_t      best;
      if (mode == MODE_SET) begin
        // Out-of-range leaves are dropped without a result.
        if (pos == 0 || pos > LEAVES) return;
        idx = pos;
        idx = idx + BASE - 1;
        tree[idx] = value;
        idx = idx >> 1;
        while (idx > 0) begin
          tree[idx] = lesser(node_at(2 * idx), node_at(2 * idx + 1));
          idx = idx >> 1;
        end
      end else begin
        best    = NEUTRAL;
        left_b  = (pos == 0) ? 1 : pos;
        right_b = (rend > LEAVES) ? LEAVES : rend;
        if (left_b <= right_b) begin
          // Open bounds climb until they become siblings.
          lo = left_b + BASE - 2;
          hi = right_b + BASE;
          while ((lo >> 1) != (hi >> 1)) begin
            if (lo[0] == 1'b0) best = lesser(best, node_at(lo + 1));
            if (hi[0] == 1'b1) best = lesser(best, node_at(hi - 1));
            lo = lo >> 1;
            hi = hi >> 1;
          end
        end
        pending_min.push_back(best);
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      fail_count++;
    endtask

    task check_result(value_t got);
      value_t want;
      if (pending_min.size() == 0) begin
        report_mismatch($sformatf("range_min %0d arrived with nothing outstanding", got));
      end else begin
        want = pending_min.pop_front();
        if (got !== want)
          report_mismatch($sformatf("range_min got %0d, want %0d", got, want));
      end
    endtask

    function int outstanding();
      return pending_min.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  range_min_scoreboard scoreboard = new();

  // Idling on: random gaps on both sides. Off: back-to-back transfers and steady ready.
  bit idling_on;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_request;
  // Leaf window that most random traffic targets, so updates and queries overlap.
  int unsigned focus_lo;

  range_minimum_segment_tree_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Give up after a generous fixed time.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, a few long ones; none while idling is off.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idling_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one item and hold it until the block takes it; idle first for a random gap.
  task automatic push_item(mode_e mode, int unsigned pos, int unsigned rend, value_t value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, value, POS_W'(rend), POS_W'(pos)};
    s_axis_tuser  = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    scoreboard.note_transfer(mode, POS_W'(pos), POS_W'(rend), value);
  endtask

  // Pause the sender until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (scoreboard.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic value_t pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return value_t'($urandom);
    if (roll < 85) return value_t'($urandom_range(0, 400)) - 200;
    case ($urandom_range(0, 4))
      0:       return value_t'(32'h8000_0000);
      1:       return value_t'(32'h7fff_ffff);
      2:       return NEUTRAL;
      3:       return NEUTRAL + 1;
      default: return NEUTRAL - 1;
    endcase
  endfunction

  function automatic int unsigned pick_leaf();
    if ($urandom_range(0, 99) < 60) return focus_lo + $urandom_range(0, 63);
    return $urandom_range(1, LEAVES);
  endfunction

  // One random item: mostly in-range updates and well-formed queries, some broken ones.
  task automatic push_random(int unsigned query_pct);
    int unsigned roll;
    int unsigned pos;
    int unsigned rend;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) >= query_pct) begin
      if (roll < 93) pos = pick_leaf();
      else if (roll < 96) pos = 0;
      else pos = $urandom_range(LEAVES + 1, 2047);
      push_item(MODE_SET, pos, $urandom_range(0, 2047), pick_value());
    end else begin
      pos = pick_leaf();
      if (roll < 45) begin
        rend = pos + $urandom_range(0, 15);
      end else if (roll < 80) begin
        rend = $urandom_range(pos, LEAVES);
      end else if (roll < 90) begin
        rend = (pos > 1) ? $urandom_range(0, pos - 1) : 0;
      end else begin
        if (roll < 95) pos = 0;
        rend = $urandom_range(LEAVES, 2047);
      end
      if (rend > 2047) rend = 2047;
      push_item(MODE_QUERY, pos, rend, value_t'($urandom));
    end
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 99) < 30) begin
        stall_left    = pick_gap();
        m_axis_tready = (stall_left == 0);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest prediction.
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) scoreboard.check_result(value_t'(m_axis_tdata));
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_request  = 1'b0;
    idling_on     = 1'b1;
    focus_lo      = 1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty tree, extreme values and leaves, clamped and empty ranges.
    push_item(MODE_QUERY, 1, LEAVES, value_t'(32'hffff_ffff));
    push_item(MODE_SET, 1, 2047, value_t'(32'h8000_0000));
    push_item(MODE_SET, LEAVES, 0, value_t'(32'h7fff_ffff));
    push_item(MODE_SET, 512, 5, 0);
    push_item(MODE_QUERY, 1, LEAVES, 0);
    push_item(MODE_QUERY, LEAVES, LEAVES, 0);
    push_item(MODE_QUERY, 2, LEAVES, 0);
    push_item(MODE_QUERY, 0, 5, 0);
    push_item(MODE_QUERY, 1000, 2047, 0);
    push_item(MODE_QUERY, 10, 5, 0);
    push_item(MODE_QUERY, 0, 0, 0);
    push_item(MODE_QUERY, 2047, 2047, 0);
    push_item(MODE_SET, 0, 3, -7);
    push_item(MODE_SET, LEAVES + 1, 3, -7);
    push_item(MODE_SET, 2047, 2047, value_t'(32'h8000_0000));
    push_item(MODE_QUERY, 1025, 2047, 0);
    push_item(MODE_QUERY, 1, 1, 0);
    // A leaf above neutral still reads back as neutral.
    push_item(MODE_SET, 1, 0, NEUTRAL + 1);
    push_item(MODE_QUERY, 1, 1, 0);
    push_item(MODE_SET, 513, 0, NEUTRAL - 1);
    push_item(MODE_QUERY, 511, 514, 0);
    push_item(MODE_QUERY, 513, LEAVES, 0);
    drain();

    for (int blk = 0; blk < 12; blk++) begin
      focus_lo  = $urandom_range(1, LEAVES - 63);
      idling_on = ($urandom_range(0, 3) != 0);
      if (blk == 3) begin
        // Long receiver hold-off while queries keep coming: the block must back up.
        idling_on    = 1'b0;
        hold_request = 1'b1;
        for (int n = 0; n < 100; n++) push_random(80);
      end else begin
        if (blk == 6) drain();
        for (int n = 0; n < 100; n++) push_random(55);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    drain();
    repeat (40) @(posedge clk_i);
    if (scoreboard.outstanding() != 0)
      scoreboard.report_mismatch($sformatf("%0d results never arrived",
                                           scoreboard.outstanding()));
    if (scoreboard.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
